@@ hdl/queue_lock_manager_assert.svh @@
// Assertion macros for the queue lock manager checker.
`ifndef QUEUE_LOCK_MANAGER_ASSERT_SVH
`define QUEUE_LOCK_MANAGER_ASSERT_SVH

// Same-cycle implication.
`define QLM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define QLM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/qlm_pkg.sv @@
`default_nettype none
package qlm_pkg;

	localparam int THREAD_NUM_W = 4;

	typedef logic [THREAD_NUM_W-1:0] thread_num_t;

	typedef enum logic {
		CMD_ACQUIRE = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

endpackage
`default_nettype wire

@@ hdl/qlm_req_if.sv @@
`default_nettype none
interface qlm_req_if;
	import qlm_pkg::*;

	logic        valid;
	logic        ready;
	cmd_t        command;
	thread_num_t thread_num;

	modport source (output valid, output command, output thread_num, input ready);
	modport sink (input valid, input command, input thread_num, output ready);

endinterface
`default_nettype wire

@@ hdl/qlm_rsp_if.sv @@
`default_nettype none
interface qlm_rsp_if;
	import qlm_pkg::*;

	logic        valid;
	logic        ready;
	logic        granted;
	thread_num_t grant_thread;
	logic        misuse;

	modport source (output valid, output granted, output grant_thread, output misuse,
		input ready);
	modport sink (input valid, input granted, input grant_thread, input misuse,
		output ready);

endinterface
`default_nettype wire

@@ hdl/queue_lock_manager.sv @@
// Queue lock manager: MCS-style lock for up to THREADS threads.
// req channel: one item per request, command (acquire or release) and
// thread number. rsp channel: exactly one item per request, in request order,
// carrying granted, grant_thread (holder after a grant, else 0) and misuse.
// An accepted request moves from the request stage into the response register,
// from which it is taken when rsp.ready is high.
// One request per cycle while rsp is not stalled. The successor table is a
// synchronous memory read at accept; the response stage writes it as the
// request advances; a same-address write is forwarded to the following request.
// Reset clears lock state, queue marks and both pipeline valids; the
// successor table is not cleared, since every entry is written before use.
// When rsp is stalled the response register holds, the request stage holds
// behind it and req.ready drops once that stage is full.
`default_nettype none
module queue_lock_manager #(
	parameter int THREADS = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	qlm_req_if.sink    req,
	qlm_rsp_if.source  rsp
);
	import qlm_pkg::*;

	localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;

	typedef logic [TW-1:0] idx_t;

	// lock state
	logic               lock_busy_q;
	thread_num_t        head_q;
	thread_num_t        tail_q;
	logic [THREADS-1:0] queued_q;

	// successor table
	thread_num_t succ_mem [THREADS];
	thread_num_t succ_rd_q;

	// request stage
	logic        valid_s1;
	cmd_t        cmd_s1;
	thread_num_t tid_s1;
	logic        fwd_hit_s1;
	thread_num_t fwd_data_s1;

	// response register
	logic        rsp_valid_q;
	logic        granted_q;
	thread_num_t grant_thread_q;
	logic        misuse_q;

	logic        advance;
	logic        accept;
	idx_t        idx;
	thread_num_t succ;
	logic        g_n;
	thread_num_t who_n;
	logic        bad_n;
	logic        wr_en;
	idx_t        wr_addr;
	thread_num_t wr_data;
	logic        set_mark;
	logic        clr_mark;
	logic        busy_n;
	thread_num_t head_n;
	thread_num_t tail_n;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	assign idx  = idx_t'(tid_s1);
	assign succ = fwd_hit_s1 ? fwd_data_s1 : succ_rd_q;

	always_comb begin
		g_n      = 1'b0;
		who_n    = '0;
		bad_n    = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = idx_t'(tail_q);
		wr_data  = tid_s1;
		set_mark = 1'b0;
		clr_mark = 1'b0;
		busy_n   = lock_busy_q;
		head_n   = head_q;
		tail_n   = tail_q;
		if (int'(tid_s1) >= THREADS) begin
			bad_n = 1'b1;
		end else if (cmd_s1 == CMD_ACQUIRE) begin
			if (queued_q[idx]) begin
				bad_n = 1'b1;
			end else begin
				set_mark = 1'b1;
				tail_n   = tid_s1;
				if (!lock_busy_q) begin
					busy_n = 1'b1;
					head_n = tid_s1;
					g_n    = 1'b1;
					who_n  = tid_s1;
				end else begin
					wr_en = 1'b1;
				end
			end
		end else begin
			if (!lock_busy_q || tid_s1 != head_q) begin
				bad_n = 1'b1;
			end else begin
				clr_mark = 1'b1;
				if (head_q == tail_q) begin
					busy_n = 1'b0;
				end else begin
					head_n = succ;
					g_n    = 1'b1;
					who_n  = succ;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			succ_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			succ_rd_q <= succ_mem[idx_t'(req.thread_num)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= req.command;
			tid_s1      <= req.thread_num;
			fwd_hit_s1  <= advance && wr_en && (wr_addr == idx_t'(req.thread_num));
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_busy_q <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			queued_q    <= '0;
		end else if (advance) begin
			lock_busy_q <= busy_n;
			head_q      <= head_n;
			tail_q      <= tail_n;
			if (set_mark) begin
				queued_q[idx] <= 1'b1;
			end else if (clr_mark) begin
				queued_q[idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			granted_q      <= g_n;
			grant_thread_q <= who_n;
			misuse_q       <= bad_n;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.granted      = granted_q;
	assign rsp.grant_thread = grant_thread_q;
	assign rsp.misuse       = misuse_q;

endmodule
`default_nettype wire

@@ hdl/qlm_checker.sv @@
`default_nettype none
`include "queue_lock_manager_assert.svh"
module qlm_checker (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       rsp_valid,
	input wire                       rsp_ready,
	input wire                       rsp_granted,
	input wire qlm_pkg::thread_num_t rsp_grant_thread,
	input wire                       rsp_misuse
);
	import qlm_pkg::*;

	`QLM_ASSERT_IMP(a_grant_not_misuse, clk, arst_n, rsp_valid && rsp_granted, !rsp_misuse, "grant flagged as misuse")
	`QLM_ASSERT_IMP(a_idle_thread_zero, clk, arst_n, rsp_valid && !rsp_granted, rsp_grant_thread == '0, "grant_thread set without grant")
	`QLM_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_granted) && $stable(rsp_grant_thread) && $stable(rsp_misuse), "stalled response changed")

endmodule

bind queue_lock_manager qlm_checker u_qlm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_granted      (rsp.granted),
	.rsp_grant_thread (rsp.grant_thread),
	.rsp_misuse       (rsp.misuse)
);
`default_nettype wire
